>>> hdl/mkbt_pkg.sv
`timescale 1ns / 1ps

package mkbt_pkg;

   localparam int KeyWidth  = 16;
   localparam int CodeWidth = 15;

   localparam logic [1:0] FUNC_PRESS   = 2'd0;
   localparam logic [1:0] FUNC_RELEASE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR   = 2'd2;

   localparam logic [KeyWidth-1:0] FORCE_CODE = 16'hffff;

   typedef logic [KeyWidth-1:0]  key_type;
   typedef logic [CodeWidth-1:0] code_type;

   typedef struct packed {
      logic down;
      logic went_down;
      logic went_up;
   } flags_type;

   typedef struct packed {
      logic changed;
      logic is_down;
      logic went_down;
      logic went_up;
      logic slots_full;
   } result_type;

endpackage

>>> hdl/mkbt_req_if.sv
`timescale 1ns / 1ps

interface mkbt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] key_code;

   modport source (output valid, output func, output key_code, input ready);
   modport sink   (input valid, input func, input key_code, output ready);
endinterface

>>> hdl/mkbt_rsp_if.sv
`timescale 1ns / 1ps

interface mkbt_rsp_if;
   logic valid;
   logic ready;
   logic changed;
   logic is_down;
   logic went_down;
   logic went_up;
   logic slots_full;

   modport source (output valid, output changed, output is_down, output went_down,
                   output went_up, output slots_full, input ready);
   modport sink   (input valid, input changed, input is_down, input went_down,
                   input went_up, input slots_full, output ready);
endinterface

>>> hdl/mkbt_slot_logic.sv
`timescale 1ns / 1ps

module mkbt_slot_logic
   import mkbt_pkg::*;
#(
   parameter int KEY_SLOTS = 4
) (
   input  logic [1:0] func,
   input  code_type   code,
   input  key_type    slots_cur [KEY_SLOTS],
   input  flags_type  flags_cur,
   output key_type    slots_nxt [KEY_SLOTS],
   output flags_type  flags_nxt,
   output result_type result
);

   key_type              code_key;
   logic [KEY_SLOTS-1:0] occupied;
   logic [KEY_SLOTS-1:0] free_first;
   logic [KEY_SLOTS-1:0] hit_first;
   logic                 any_match;
   logic                 others_held;

   assign code_key = {1'b0, code};

   // lowest free slot and lowest slot holding the code
   always_comb begin
      logic found_free;
      logic found_hit;
      found_free = 1'b0;
      found_hit  = 1'b0;
      any_match  = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         occupied[i]   = (slots_cur[i] != '0);
         free_first[i] = !occupied[i] && !found_free;
         found_free    = found_free || !occupied[i];
         hit_first[i]  = occupied[i] && (slots_cur[i] == code_key) && !found_hit;
         found_hit     = found_hit || hit_first[i];
         any_match     = any_match || (slots_cur[i] == code_key);
      end
   end

   assign others_held = |(occupied & ~hit_first);

   always_comb begin
      slots_nxt = slots_cur;
      flags_nxt = flags_cur;
      result    = '0;
      case (func)
         FUNC_PRESS: begin
            if (code == '0) begin
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  slots_nxt[i] = '0;
               end
               slots_nxt[0]        = FORCE_CODE;
               flags_nxt.down      = 1'b1;
               flags_nxt.went_down = 1'b1;
               result.changed      = !flags_cur.down;
            end else if (any_match) begin
               result.changed = 1'b0;
            end else if (free_first == '0) begin
               result.slots_full = 1'b1;
            end else begin
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  if (free_first[i]) begin
                     slots_nxt[i] = code_key;
                  end
               end
               flags_nxt.down      = 1'b1;
               flags_nxt.went_down = 1'b1;
               result.changed      = !flags_cur.down;
            end
         end
         FUNC_RELEASE: begin
            if (code == '0) begin
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  slots_nxt[i] = '0;
               end
               flags_nxt.went_up = 1'b1;
               flags_nxt.down    = 1'b0;
               result.changed    = flags_cur.down;
            end else if (hit_first != '0) begin
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  if (hit_first[i]) begin
                     slots_nxt[i] = '0;
                  end
               end
               flags_nxt.went_up = 1'b1;
               if (!others_held) begin
                  flags_nxt.down = 1'b0;
               end
               result.changed = flags_cur.down && !others_held;
            end
         end
         FUNC_CLEAR: begin
            flags_nxt.went_down = 1'b0;
            flags_nxt.went_up   = 1'b0;
         end
         default: begin
            flags_nxt = flags_cur;
         end
      endcase
      result.is_down   = flags_nxt.down;
      result.went_down = flags_nxt.went_down;
      result.went_up   = flags_nxt.went_up;
   end

endmodule

>>> hdl/multi_key_button_tracker.sv
`timescale 1ns / 1ps
// path: an accepted item goes to the input register, then to the result register once that can take it
// throughput: one item per cycle while the result side keeps taking items
// the key slot state is updated in the same cycle the result register is loaded
// reset: synchronous, active high; clears both valid stages, all key slots and all flags

module multi_key_button_tracker
   import mkbt_pkg::*;
#(
   parameter int KEY_SLOTS = 4
) (
   input logic        clock,
   input logic        reset,
   mkbt_req_if.sink   req_chan,
   mkbt_rsp_if.source rsp_chan
);

   logic       req_valid_ff;
   logic       req_valid_in;
   logic [1:0] req_func_ff;
   logic [1:0] req_func_in;
   code_type   req_code_ff;
   code_type   req_code_in;

   key_type    slots_ff [KEY_SLOTS];
   key_type    slots_in [KEY_SLOTS];
   key_type    slots_nxt [KEY_SLOTS];
   flags_type  flags_ff;
   flags_type  flags_in;
   flags_type  flags_nxt;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;
   result_type rsp_data_in;
   result_type result;

   logic       advance;
   logic       req_take;

   mkbt_slot_logic #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_slot_logic (
      .func      (req_func_ff),
      .code      (req_code_ff),
      .slots_cur (slots_ff),
      .flags_cur (flags_ff),
      .slots_nxt (slots_nxt),
      .flags_nxt (flags_nxt),
      .result    (result)
   );

   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !advance);
      req_func_in  = req_take ? req_chan.func : req_func_ff;
      req_code_in  = req_take ? req_chan.key_code[CodeWidth-1:0] : req_code_ff;
      if (advance) begin
         slots_in = slots_nxt;
      end else begin
         slots_in = slots_ff;
      end
      flags_in     = advance ? flags_nxt : flags_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
      rsp_data_in  = advance ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= '0;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
         slots_ff     <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      req_func_ff <= req_func_in;
      req_code_ff <= req_code_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.changed    = rsp_data_ff.changed;
   assign rsp_chan.is_down    = rsp_data_ff.is_down;
   assign rsp_chan.went_down  = rsp_data_ff.went_down;
   assign rsp_chan.went_up    = rsp_data_ff.went_up;
   assign rsp_chan.slots_full = rsp_data_ff.slots_full;

endmodule
